[sv/erd_pkg.sv]
`default_nettype none

package erd_pkg;

	// Field widths fixed by the item formats
	localparam int FLOOR_W    = 4;
	localparam int PICK_W     = 3;
	localparam int PEND_W     = 4;
	localparam int CFG_DATA_W = 4;

	// Default number of floors with a request bit
	localparam int MAX_FLOORS_DEF = 8;

	// Reset value of the floors-in-use register
	localparam int FLOORS_RESET = 5;

	typedef enum logic {
		KIND_CALL     = 1'b0,
		KIND_DISPATCH = 1'b1
	} kind_t;

	typedef enum logic {
		REG_SCAN_MODE     = 1'b0,
		REG_FLOORS_IN_USE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		kind_t              kind;
		logic [FLOOR_W-1:0] floor;
		logic [PICK_W-1:0]  pick_index;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic [FLOOR_W-1:0] served_floor;
		logic               went_down;
		logic [PEND_W-1:0]  pending;
	} result_t;

endpackage

`default_nettype wire

[sv/elevator_request_dispatcher_unit.sv]
`default_nettype none

// Channel   Handshake                  Payload              Direction
// item      item_valid / item_stall    erd_pkg::item_t      in
// result    result_valid / result_stall erd_pkg::result_t   out
// config    cfg_write                  cfg_index, cfg_data  in
//
// One transaction per clock while not stalled; a result passes through the
// input register, then the result register, before result_valid shows it.
// The dispatcher state updates at the same edge that loads the result
// register, so the next item sees it without a bubble.
// arst_n clears state: no requests, cab at floor 1, direction up, naive mode,
// five floors in use. item_stall rises only while the result register is
// full and stalled and the input register holds a waiting transaction.
module elevator_request_dispatcher_unit #(
	parameter int MAX_FLOORS = erd_pkg::MAX_FLOORS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire erd_pkg::reg_idx_t              cfg_index,
	input  wire logic [erd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire erd_pkg::item_t                 item,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output erd_pkg::result_t                    result
);

	localparam int FW = erd_pkg::FLOOR_W;
	localparam int CNT_W = $clog2(MAX_FLOORS + 1);

	// Input stage
	logic             valid_s1;
	erd_pkg::item_t   item_s1;

	// Result stage
	logic             valid_s2;
	erd_pkg::result_t result_s2;

	logic             advance, fire;

	// State seen by the selector
	logic                  scan_mode, last_down;
	logic [FW-1:0]         top, cab_floor, served;
	logic [MAX_FLOORS-1:0] request_bits;
	logic [CNT_W-1:0]      pending_count;
	erd_pkg::result_t      next_result;

	// Move forward whenever the result register is empty or being drained
	assign advance    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) valid_s1 <= item_valid;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	// Payload: load input on accept, result on fire; hold otherwise
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) item_s1 <= item;
		if (fire) result_s2 <= next_result;
	end

	erd_state #(
		.MAX_FLOORS(MAX_FLOORS)
	) u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fire         (fire),
		.item         (item_s1),
		.served       (served),
		.scan_mode    (scan_mode),
		.top          (top),
		.cab_floor    (cab_floor),
		.last_down    (last_down),
		.request_bits (request_bits),
		.pending_count(pending_count),
		.next_result  (next_result)
	);

	erd_pick #(
		.MAX_FLOORS(MAX_FLOORS)
	) u_pick (
		.scan_mode    (scan_mode),
		.top          (top),
		.cab_floor    (cab_floor),
		.last_down    (last_down),
		.request_bits (request_bits),
		.pending_count(pending_count),
		.pick_index   (item_s1.pick_index),
		.served       (served)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Pending count tracks the request bits exactly
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		pending_count == CNT_W'($countones(request_bits)))
		else $error("pending count differs from request bits");

	// Cab stays on a served floor
	a_cab_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cab_floor != '0 && cab_floor <= top)
		else $error("cab floor outside served range");

	// A blocked input transaction is held, not dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input transaction lost while result stalled");

endmodule

`default_nettype wire

[sv/erd_pick.sv]
`default_nettype none

// Next-floor selection: directional scan or rank pick among pending floors.
module erd_pick #(
	parameter int MAX_FLOORS = erd_pkg::MAX_FLOORS_DEF,
	localparam int FW = erd_pkg::FLOOR_W,
	localparam int CNT_W = $clog2(MAX_FLOORS + 1)
) (
	input  wire logic                        scan_mode,
	input  wire logic [FW-1:0]               top,
	input  wire logic [FW-1:0]               cab_floor,
	input  wire logic                        last_down,
	input  wire logic [MAX_FLOORS-1:0]       request_bits,
	input  wire logic [CNT_W-1:0]            pending_count,
	input  wire logic [erd_pkg::PICK_W-1:0]  pick_index,
	output logic [FW-1:0]                    served
);

	localparam int EXT_W = FW + 1;
	localparam int K_W = (CNT_W > erd_pkg::PICK_W) ? CNT_W : erd_pkg::PICK_W;

	// Highest set floor when from_top, lowest otherwise; 0 when empty
	function automatic logic [FW-1:0] first_floor(input logic [MAX_FLOORS-1:0] v,
		input logic from_top);
		logic [FW-1:0] f;
		f = '0;
		for (int j = 0; j < MAX_FLOORS; j++) begin
			if (from_top) begin
				if (v[j]) f = FW'(j + 1);
			end else begin
				if (v[MAX_FLOORS-1-j]) f = FW'(MAX_FLOORS - j);
			end
		end
		return f;
	endfunction

	logic [MAX_FLOORS-1:0] below, above;
	logic [MAX_FLOORS-1:0] near_set, far_set;
	logic                  eff_down;
	logic [FW-1:0]         scan_floor, naive_floor;
	logic [K_W-1:0]        rank [MAX_FLOORS];
	logic [K_W-1:0]        k_lim, k_idx, k_sel;

	always_comb begin
		for (int j = 0; j < MAX_FLOORS; j++) begin
			below[j] = EXT_W'(j + 1) < {1'b0, cab_floor};
			above[j] = EXT_W'(j + 1) > {1'b0, cab_floor};
		end
		// reverse first when already standing at the end floor
		eff_down = last_down ? (cab_floor > FW'(1)) : (cab_floor >= top);
		near_set = request_bits & (eff_down ? below : above);
		far_set  = request_bits & ~(eff_down ? below : above);
		if (near_set != '0) begin
			scan_floor = first_floor(near_set, eff_down);
		end else begin
			scan_floor = first_floor(far_set, !eff_down);
		end
	end

	always_comb begin
		k_lim = K_W'(pending_count) - K_W'(1);
		k_idx = K_W'(pick_index);
		k_sel = (k_idx > k_lim) ? k_lim : k_idx;
		naive_floor = '0;
		for (int j = 0; j < MAX_FLOORS; j++) begin
			rank[j] = K_W'($countones(request_bits &
				((MAX_FLOORS'(1) << j) - MAX_FLOORS'(1))));
			if (request_bits[j] && rank[j] == k_sel) naive_floor = FW'(j + 1);
		end
	end

	assign served = scan_mode ? scan_floor : naive_floor;

endmodule

`default_nettype wire

[sv/erd_state.sv]
`default_nettype none

// Dispatcher state, configuration registers and per-transaction update.
module erd_state #(
	parameter int MAX_FLOORS = erd_pkg::MAX_FLOORS_DEF,
	localparam int FW = erd_pkg::FLOOR_W,
	localparam int CNT_W = $clog2(MAX_FLOORS + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire erd_pkg::reg_idx_t              cfg_index,
	input  wire logic [erd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           fire,
	input  wire erd_pkg::item_t                 item,
	input  wire logic [FW-1:0]                  served,
	output logic                                scan_mode,
	output logic [FW-1:0]                       top,
	output logic [FW-1:0]                       cab_floor,
	output logic                                last_down,
	output logic [MAX_FLOORS-1:0]               request_bits,
	output logic [CNT_W-1:0]                    pending_count,
	output erd_pkg::result_t                    next_result
);

	localparam int EXT_W = FW + 1;
	localparam int FLOOR_MAX = 2 ** FW - 1;
	localparam int TOP_CAP = (MAX_FLOORS > FLOOR_MAX) ? FLOOR_MAX : MAX_FLOORS;
	localparam int TOP_RESET = (erd_pkg::FLOORS_RESET > TOP_CAP) ? TOP_CAP :
		erd_pkg::FLOORS_RESET;

	logic                  scan_q, scan_d;
	logic [FW-1:0]         top_q, top_d;
	logic [FW-1:0]         cab_q, cab_d;
	logic                  down_q, down_d;
	logic [MAX_FLOORS-1:0] bits_q, bits_d;
	logic [CNT_W-1:0]      count_q, count_d;

	logic [FW-1:0]         new_top;
	logic [MAX_FLOORS-1:0] keep, dec, clr;
	logic                  call_ok, serve_ok;

	always_comb begin
		if (cfg_data[FW-1:0] == '0) begin
			new_top = FW'(1);
		end else if (cfg_data[FW-1:0] > FW'(TOP_CAP)) begin
			new_top = FW'(TOP_CAP);
		end else begin
			new_top = cfg_data[FW-1:0];
		end
		for (int j = 0; j < MAX_FLOORS; j++) begin
			keep[j] = EXT_W'(j + 1) <= {1'b0, new_top};
			dec[j]  = EXT_W'(j + 1) == {1'b0, item.floor};
			clr[j]  = EXT_W'(j + 1) == {1'b0, served};
		end
		call_ok = (item.kind == erd_pkg::KIND_CALL) && (item.floor != '0) &&
			(item.floor <= top_q) && ((bits_q & dec) == '0);
		serve_ok = (item.kind == erd_pkg::KIND_DISPATCH) && (count_q != '0) &&
			(served != '0);

		scan_d  = scan_q;
		top_d   = top_q;
		cab_d   = cab_q;
		down_d  = down_q;
		bits_d  = bits_q;
		count_d = count_q;
		if (cfg_write) begin
			unique case (cfg_index)
				erd_pkg::REG_SCAN_MODE: begin
					scan_d = cfg_data[0];
				end
				erd_pkg::REG_FLOORS_IN_USE: begin
					// drop requests above the new top, recount and clamp the cab to the new top
					top_d   = new_top;
					bits_d  = bits_q & keep;
					count_d = CNT_W'($countones(bits_q & keep));
					cab_d   = (cab_q > new_top) ? new_top : cab_q;
				end
			endcase
		end else if (fire) begin
			if (call_ok) begin
				bits_d  = bits_q | dec;
				count_d = count_q + CNT_W'(1);
			end
			if (serve_ok) begin
				down_d  = served < cab_q;
				cab_d   = served;
				bits_d  = bits_q & ~clr;
				count_d = count_q - CNT_W'(1);
			end
		end

		next_result.accepted     = call_ok;
		next_result.served_floor = serve_ok ? served : '0;
		next_result.went_down    = down_d;
		next_result.pending      = erd_pkg::PEND_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= 1'b0;
			top_q   <= FW'(TOP_RESET);
			cab_q   <= FW'(1);
			down_q  <= 1'b0;
			bits_q  <= '0;
			count_q <= '0;
		end else begin
			scan_q  <= scan_d;
			top_q   <= top_d;
			cab_q   <= cab_d;
			down_q  <= down_d;
			bits_q  <= bits_d;
			count_q <= count_d;
		end
	end

	assign scan_mode     = scan_q;
	assign top           = top_q;
	assign cab_floor     = cab_q;
	assign last_down     = down_q;
	assign request_bits  = bits_q;
	assign pending_count = count_q;

endmodule

`default_nettype wire
